>>> rtl/ordered_set_kth_largest_assert.svh
// ----------------------------------------------------------------------------
// ordered set k-th largest: assertion macros
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SET_KTH_LARGEST_ASSERT_SVH
`define ORDERED_SET_KTH_LARGEST_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define OSKL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered set check failed");

// next-cycle implication, sampled on clock, off during reset
`define OSKL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered set check failed");

`endif

>>> rtl/oskl_pkg.sv
// ----------------------------------------------------------------------------
// oskl_pkg
// Sizes, codes and shared types of the ordered set k-th largest block.
// ----------------------------------------------------------------------------
package oskl_pkg;

   // store size and field widths
   localparam int CAPACITY = 1024;
   localparam int KEY_W    = 32;
   localparam int ENTRY_W  = 11;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   // reduction tree over the cells: a register every REG_EVERY levels
   localparam int TREE_N     = 1 << IDX_W;
   localparam int REG_EVERY  = 4;
   localparam int REDUCE_LAT = IDX_W / REG_EVERY;
   localparam int WAIT_W     = (REDUCE_LAT > 0) ? $clog2(REDUCE_LAT + 1) : 1;

   // operation codes
   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_ERASE  = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   // result status codes
   typedef enum logic [2:0] {
      STAT_OK     = 3'd0,
      STAT_DUP    = 3'd1,
      STAT_ABSENT = 3'd2,
      STAT_FULL   = 3'd3,
      STAT_RANGE  = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_WAIT
   } state_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic             eval;
      logic             ins;
      logic             del;
      logic [KEY_W-1:0] op;
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] qidx;
   } cell_ctl_type;

   // per-cell finding, merged up the tree
   typedef struct packed {
      logic             found;
      logic [KEY_W-1:0] value;
   } leaf_type;

endpackage

>>> rtl/oskl_cell.sv
// ----------------------------------------------------------------------------
// oskl_cell
// One slot of the sorted chain: holds a key, compares it with the operand
// and shifts towards or away from its neighbours on insert and erase.
// ----------------------------------------------------------------------------
module oskl_cell
   import oskl_pkg::*;
(
   input  logic                 clock,
   input  cell_ctl_type         ctl,
   input  logic [IDX_W-1:0]     cell_index,
   input  logic [KEY_W-1:0]     prev_key,
   input  logic                 prev_lt,
   input  logic [KEY_W-1:0]     next_key,
   output logic [KEY_W-1:0]     key_out,
   output logic                 lt_out,
   output leaf_type             leaf_out
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   leaf_type         leaf_ff;
   leaf_type         leaf_in;
   logic             held;
   logic             lt;
   logic             eq;
   logic             sel;

   // local compares against the broadcast operand
   always_comb begin
      held = (CNT_W'(cell_index) < ctl.count);
      lt   = held && ($signed(key_ff) < $signed(ctl.op));
      eq   = held && (key_ff == ctl.op);
      sel  = (cell_index == ctl.qidx);
   end

   // shift rules: keys below the operand stay, the rest move one place
   always_comb begin
      key_in  = key_ff;
      leaf_in = leaf_ff;
      if (ctl.ins) begin
         if (lt) begin
            key_in = key_ff;
         end else if (prev_lt) begin
            key_in = ctl.op;
         end else begin
            key_in = prev_key;
         end
      end else if (ctl.del) begin
         key_in = lt ? key_ff : next_key;
      end
      if (ctl.eval) begin
         leaf_in.found = eq;
         leaf_in.value = sel ? key_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      leaf_ff <= leaf_in;
   end

   assign key_out  = key_ff;
   assign lt_out   = lt;
   assign leaf_out = leaf_ff;

endmodule

>>> rtl/oskl_reduce.sv
// ----------------------------------------------------------------------------
// oskl_reduce
// OR tree over the cell findings, registered every few levels, giving the
// match flag and the selected key at the root.
// ----------------------------------------------------------------------------
module oskl_reduce
   import oskl_pkg::*;
(
   input  logic     clock,
   input  leaf_type leaves [CAPACITY],
   output leaf_type root
);

   // heap layout: node 1 is the root, leaves from TREE_N upwards
   leaf_type node [2*TREE_N];

   // leaves, padded with empty findings up to a power of two
   for (genvar i = 0; i < TREE_N; i++) begin : g_leaf
      if (i < CAPACITY) begin : g_used
         assign node[TREE_N + i] = leaves[i];
      end else begin : g_pad
         assign node[TREE_N + i] = '0;
      end
   end

   // inner nodes
   for (genvar j = 1; j < TREE_N; j++) begin : g_node
      localparam int LEVEL  = $clog2(j + 1) - 1;
      localparam int HEIGHT = IDX_W - LEVEL;
      leaf_type merged;
      always_comb begin
         merged.found = node[2*j].found | node[2*j + 1].found;
         merged.value = node[2*j].value | node[2*j + 1].value;
      end
      if ((HEIGHT % REG_EVERY) == 0) begin : g_reg
         always_ff @(posedge clock) begin
            node[j] <= merged;
         end
      end else begin : g_comb
         assign node[j] = merged;
      end
   end

   // unused heap slot
   assign node[0] = '0;

   assign root = node[1];

endmodule

>>> rtl/ordered_set_kth_largest.sv
// ----------------------------------------------------------------------------
// ordered_set_kth_largest
// Set of distinct signed keys kept sorted in a chain of cells, with
// insert, erase and k-th largest query.
//
//   channel   direction  ports                                  handshake
//   req_      in         req_action, req_operand                valid/stall
//   rsp_      out        rsp_result_value, rsp_status,          valid/stall
//                        rsp_entry_count
//
// Each item runs a compare in every cell, then the registered OR tree
// that collects match and query key from all cells, then the shift of
// the chain in the cycle of the result. Reset clears the key count and
// the control state; cell contents need no clearing pass. A stalled
// result holds; the following item completes once it is taken.
// ----------------------------------------------------------------------------
module ordered_set_kth_largest
   import oskl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_action,
   input  logic signed [KEY_W-1:0] req_operand,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [KEY_W-1:0] rsp_result_value,
   output logic [2:0]              rsp_status,
   output logic [ENTRY_W-1:0]      rsp_entry_count
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0] rsp_count_ff, rsp_count_in;
   logic [1:0]         action_ff;
   logic [KEY_W-1:0]   op_ff;

   cell_ctl_type       ctl;
   logic               range_ok;
   logic               full;
   logic [CNT_W-1:0]   qdiff;
   logic               accept;
   leaf_type           root;

   logic [KEY_W-1:0]   key_w  [CAPACITY];
   logic               lt_w   [CAPACITY];
   leaf_type           leaf_w [CAPACITY];

   // input handshake
   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // rank checks and the cell index of the k-th largest key
   always_comb begin
      range_ok = !op_ff[KEY_W-1] && (op_ff != '0) && (op_ff <= KEY_W'(count_ff));
      full     = (count_ff == CNT_W'(CAPACITY));
      qdiff    = count_ff - op_ff[CNT_W-1:0];
   end

   // sequencer: next state, cell strobes and result
   always_comb begin
      state_in      = state_ff;
      wait_in       = wait_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ctl.eval      = 1'b0;
      ctl.ins       = 1'b0;
      ctl.del       = 1'b0;
      ctl.op        = op_ff;
      ctl.count     = count_ff;
      ctl.qidx      = qdiff[IDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            ctl.eval = 1'b1;
            wait_in  = '0;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (wait_ff != WAIT_W'(REDUCE_LAT)) begin
               wait_in = wait_ff + 1'b1;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_value_in  = '0;
               rsp_status_in = STAT_OK;
               case (action_ff)
                  ACT_INSERT: begin
                     if (root.found) begin
                        rsp_status_in = STAT_DUP;
                     end else if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        ctl.ins  = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_ERASE: begin
                     if (root.found) begin
                        ctl.del  = 1'b1;
                        count_in = count_ff - 1'b1;
                     end else begin
                        rsp_status_in = STAT_ABSENT;
                     end
                  end
                  ACT_QUERY: begin
                     if (range_ok) begin
                        rsp_value_in = root.value;
                     end else begin
                        rsp_status_in = STAT_RANGE;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
               rsp_count_in = ENTRY_W'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         op_ff     <= req_operand;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // chain of key cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_W-1:0] prev_key;
      logic             prev_lt;
      logic [KEY_W-1:0] next_key;
      if (i == 0) begin : g_first
         assign prev_key = key_w[i];
         assign prev_lt  = 1'b1;
      end else begin : g_mid
         assign prev_key = key_w[i-1];
         assign prev_lt  = lt_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_key = key_w[i];
      end else begin : g_inner
         assign next_key = key_w[i+1];
      end
      oskl_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_index (IDX_W'(i)),
         .prev_key   (prev_key),
         .prev_lt    (prev_lt),
         .next_key   (next_key),
         .key_out    (key_w[i]),
         .lt_out     (lt_w[i]),
         .leaf_out   (leaf_w[i])
      );
   end

   // match and query key collected over all cells
   oskl_reduce u_reduce (
      .clock  (clock),
      .leaves (leaf_w),
      .root   (root)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

>>> rtl/oskl_checker.sv
// ----------------------------------------------------------------------------
// oskl_checker
// Port-level checks on the ordered set block, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_set_kth_largest_assert.svh"

module oskl_checker
   import oskl_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [KEY_W-1:0] rsp_result_value,
   input logic [2:0]              rsp_status,
   input logic [ENTRY_W-1:0]      rsp_entry_count
);

   logic                       req_take;
   logic                       rsp_hold;
   logic                       rsp_full;
   logic [KEY_W+3+ENTRY_W-1:0] rsp_payload;

   assign req_take    = req_valid && !req_stall;
   assign rsp_hold    = rsp_valid && rsp_stall;
   assign rsp_full    = rsp_valid && (rsp_status == STAT_FULL);
   assign rsp_payload = {rsp_result_value, rsp_status, rsp_entry_count};

   // a stalled result keeps its payload
   `OSKL_ASSERT_NEXT(a_rsp_hold, rsp_hold, rsp_valid && $stable(rsp_payload))

   // one item at a time: busy right after an accepted item
   `OSKL_ASSERT_NEXT(a_busy_after_take, req_take, req_stall)

   // a key value is only reported with a good status
   `OSKL_ASSERT_NOW(a_value_ok, rsp_valid && rsp_result_value != 0, rsp_status == STAT_OK)

   // a full refusal reports a full store
   `OSKL_ASSERT_NOW(a_full_count, rsp_full, rsp_entry_count == ENTRY_W'(CAPACITY))

   // count never exceeds the store size
   `OSKL_ASSERT_NOW(a_count_max, rsp_valid, 32'(rsp_entry_count) <= 32'(CAPACITY))

endmodule

bind ordered_set_kth_largest oskl_checker u_checker (.*);
